// File: design/sorted_priority_queue_defines.svh
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// check a property on every clock edge outside of reset
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] EMPTY_DATA = -32'sd1;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] item_data;
        logic signed [31:0] item_priority;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] head_data;
        logic [4:0]         occupancy;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] data;
        logic signed [31:0] prio;
    } t_entry;

    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } t_ctl;

endpackage

// File: design/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic           i_clk,
    input  spq_pkg::t_ctl   i_ctl,
    input  logic           i_valid,
    input  logic           i_is_head,
    input  logic           i_left_past,
    input  spq_pkg::t_entry i_new,
    input  spq_pkg::t_entry i_left,
    input  spq_pkg::t_entry i_right,
    output logic           o_past,
    output spq_pkg::t_entry o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_lt;
    logic            w_eq;

    assign w_lt    = r_entry.prio < i_new.prio;
    assign w_eq    = r_entry.prio == i_new.prio;
    assign o_past  = i_valid && (w_lt || (i_is_head && w_eq));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.remove_en) begin
            n_entry = i_right;
        end else if (i_ctl.insert_en && !o_past) begin
            n_entry = i_left_past ? i_new : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// The response to an accepted request is registered and shows in the next cycle.
// Throughput: one request per cycle while o_req_stall is low; every cell compares
// its priority with the incoming one in parallel and shifts by at most one place
// per cycle. Reset clears the entry count and the response valid; entry contents
// are not cleared and are never read before they are written.

`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  spq_pkg::t_req i_req,
    output logic          o_req_stall,
    output logic          o_rsp_valid,
    output spq_pkg::t_rsp o_rsp,
    input  logic          i_rsp_stall
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_rsp_valid;
    logic            n_rsp_valid;
    spq_pkg::t_rsp   r_rsp;
    spq_pkg::t_rsp   n_rsp;

    logic            w_fire;
    logic            w_empty;
    logic            w_full;
    spq_pkg::t_ctl   w_ctl;
    spq_pkg::t_entry w_new;
    spq_pkg::t_entry w_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_past;

    assign o_req_stall = r_rsp_valid && i_rsp_stall;
    assign w_fire      = i_req_valid && !o_req_stall;
    assign w_empty     = r_count == '0;
    assign w_full      = r_count == CW'(QUEUE_DEPTH);

    assign w_ctl.insert_en = w_fire && (i_req.op == spq_pkg::OP_INSERT) && !w_full;
    assign w_ctl.remove_en = w_fire && (i_req.op == spq_pkg::OP_REMOVE) && !w_empty;

    assign w_new.data = i_req.item_data;
    assign w_new.prio = i_req.item_priority;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_past;

        if (g == 0) begin : g_first
            assign w_left      = w_new;
            assign w_left_past = 1'b1;
        end else begin : g_inner
            assign w_left      = w_entry[g-1];
            assign w_left_past = w_past[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_valid     (CW'(g) < r_count),
            .i_is_head   (g == 0),
            .i_left_past (w_left_past),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_past      (w_past[g]),
            .o_entry     (w_entry[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        if (w_fire) begin
            n_rsp_valid     = 1'b1;
            n_rsp.status    = spq_pkg::ST_OK;
            n_rsp.head_data = '0;
            case (i_req.op)
                spq_pkg::OP_INSERT: begin
                    if (w_full) begin
                        n_rsp.status = spq_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                spq_pkg::OP_REMOVE, spq_pkg::OP_PEEK: begin
                    if (w_empty) begin
                        n_rsp.status    = spq_pkg::ST_EMPTY;
                        n_rsp.head_data = spq_pkg::EMPTY_DATA;
                    end else begin
                        n_rsp.head_data = w_entry[0].data;
                        if (i_req.op == spq_pkg::OP_REMOVE) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            n_rsp.occupancy = 5'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(QUEUE_DEPTH), "entry count above depth")
    `SPQ_ASSERT(a_remove_count, i_clk, i_rst_n, w_ctl.remove_en |=> r_count == $past(r_count) - 1'b1, "remove did not drop count")
    `SPQ_ASSERT(a_full_drop, i_clk, i_rst_n, (w_fire && i_req.op == spq_pkg::OP_INSERT && w_full) |=> (r_rsp.status == spq_pkg::ST_FULL && $stable(r_count)), "full insert not dropped")
    `SPQ_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (r_count == '0 && !r_rsp_valid), "reset did not clear state")

endmodule

// File: bench/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

    localparam int         QDEPTH      = 16;
    localparam int         LONG_HOLD   = 64;
    localparam int         CYCLE_LIMIT = 300000;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    class pq_mirror;
        logic signed [31:0] data_mem [QDEPTH];
        logic signed [31:0] prio_mem [QDEPTH];
        int                 held;
        spq_pkg::t_rsp      pending_rsp [$];
        int                 errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void note_request(spq_pkg::t_req r);
            spq_pkg::t_rsp rsp;
            int            slot;
            rsp.status    = spq_pkg::ST_OK;
            rsp.head_data = '0;
            case (r.op)
                spq_pkg::OP_INSERT: begin
                    if (held >= QDEPTH) begin
                        rsp.status = spq_pkg::ST_FULL;
                    end else begin
                        if (held == 0 || r.item_priority < prio_mem[0]) begin
                            slot = 0;
                        end else begin
                            slot = 1;
                            while (slot < held && prio_mem[slot] < r.item_priority)
                                slot++;
                        end
                        for (int k = held; k > slot; k--) begin
                            data_mem[k] = data_mem[k-1];
                            prio_mem[k] = prio_mem[k-1];
                        end
                        data_mem[slot] = r.item_data;
                        prio_mem[slot] = r.item_priority;
                        held++;
                    end
                end
                spq_pkg::OP_REMOVE, spq_pkg::OP_PEEK: begin
                    if (held == 0) begin
                        rsp.status    = spq_pkg::ST_EMPTY;
                        rsp.head_data = spq_pkg::EMPTY_DATA;
                    end else begin
                        rsp.head_data = data_mem[0];
                        if (r.op == spq_pkg::OP_REMOVE) begin
                            for (int k = 0; k < held - 1; k++) begin
                                data_mem[k] = data_mem[k+1];
                                prio_mem[k] = prio_mem[k+1];
                            end
                            held--;
                        end
                    end
                end
                default: ;
            endcase
            rsp.occupancy = 5'(held);
            pending_rsp.push_back(rsp);
        endfunction

        function void check_response(spq_pkg::t_rsp got);
            spq_pkg::t_rsp want;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response, expected none actual %p", $time, got);
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.head_data !== want.head_data) begin
                $display("%0t: head_data mismatch, expected %0d actual %0d",
                         $time, want.head_data, got.head_data);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $display("%0t: occupancy mismatch, expected %0d actual %0d",
                         $time, want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n     = 1'b0;
    logic          i_req_valid = 1'b0;
    spq_pkg::t_req i_req       = '0;
    logic          i_rsp_stall = 1'b0;
    logic          o_req_stall;
    logic          o_rsp_valid;
    spq_pkg::t_rsp o_rsp;

    pq_mirror sb = new();
    bit       calm;
    bit       long_hold_pending;
    int       cycle_count;

    sorted_priority_queue #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .i_req      (i_req),
        .o_req_stall(o_req_stall),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp),
        .i_rsp_stall(i_rsp_stall)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && !o_req_stall)
                sb.note_request(i_req);
            if (o_rsp_valid && !i_rsp_stall)
                sb.check_response(o_rsp);
        end
    end

    initial begin : rsp_side
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_pending) begin
                hold              = LONG_HOLD;
                long_hold_pending = 1'b0;
            end else begin
                hold = calm ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0) begin
                i_rsp_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_rsp_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_rsp_valid) @(posedge i_clk);
        end
    end

    function automatic spq_pkg::t_req make_request(logic [1:0] op, logic [31:0] data,
                                                   logic [31:0] prio);
        spq_pkg::t_req r;
        r.op            = op;
        r.item_data     = data;
        r.item_priority = prio;
        return r;
    endfunction

    function automatic spq_pkg::t_req random_request(int insert_pct, bit tight_prio);
        int          roll;
        int          pick;
        logic [1:0]  op;
        logic [31:0] prio;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            op = OP_UNUSED;
        else if (roll < insert_pct)
            op = spq_pkg::OP_INSERT;
        else
            op = ($urandom_range(0, 2) == 0) ? spq_pkg::OP_PEEK : spq_pkg::OP_REMOVE;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            prio = 32'h8000_0000;
        else if (pick == 1)
            prio = 32'h7fff_ffff;
        else if (tight_prio)
            prio = 32'($urandom_range(0, 7)) - 32'd4;
        else
            prio = $urandom;
        return make_request(op, $urandom, prio);
    endfunction

    task automatic send_request(spq_pkg::t_req r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        spq_pkg::t_req directed [$];
        int            insert_pct;
        bit            tight_prio;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: remove, peek, no-op
        directed.push_back(make_request(spq_pkg::OP_REMOVE, 32'h1234_5678, 32'd0));
        directed.push_back(make_request(spq_pkg::OP_PEEK, 32'hffff_ffff, 32'hffff_ffff));
        directed.push_back(make_request(OP_UNUSED, 32'h5555_aaaa, 32'haaaa_5555));
        // extremes and ties with the head
        directed.push_back(make_request(spq_pkg::OP_INSERT, 32'h7fff_ffff, 32'd0));
        directed.push_back(make_request(spq_pkg::OP_INSERT, 32'h8000_0000, 32'd0));
        directed.push_back(make_request(spq_pkg::OP_INSERT, 32'hffff_ffff, 32'h8000_0000));
        directed.push_back(make_request(spq_pkg::OP_INSERT, 32'd1, 32'h7fff_ffff));
        for (int k = 0; k < QDEPTH - 4; k++)
            directed.push_back(make_request(spq_pkg::OP_INSERT, $urandom,
                                            32'($urandom_range(0, 5)) - 32'd2));
        // full queue
        directed.push_back(make_request(spq_pkg::OP_INSERT, 32'hdead_beef, 32'h8000_0000));
        directed.push_back(make_request(OP_UNUSED, 32'd0, 32'd0));
        directed.push_back(make_request(spq_pkg::OP_PEEK, 32'd0, 32'd0));
        directed.push_back(make_request(spq_pkg::OP_REMOVE, 32'd0, 32'd0));
        foreach (directed[k])
            send_request(directed[k]);
        wait_drained();

        for (int seg = 0; seg < 14; seg++) begin
            case ($urandom_range(0, 2))
                0:       insert_pct = 80;
                1:       insert_pct = 30;
                default: insert_pct = 57;
            endcase
            tight_prio = $urandom_range(0, 1);
            calm       = (seg == 3 || seg == 6);
            if (seg == 6)
                long_hold_pending = 1'b1;
            for (int n = 0; n < 48; n++)
                send_request(random_request(insert_pct, tight_prio));
            if (seg == 6 || seg == 10)
                wait_drained();
        end
        calm = 1'b0;

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
